[hw/rtl/ycbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ycbs_pkg: shared types and constants of the ycbcr to bgra nearest scaler
// Dimension widths, configuration register indexes, color coefficients and
// the control state encoding.
// ----------------------------------------------------------------------------
package ycbs_pkg;

  // frame dimensions and position counters
  localparam int DIM_W       = 13;
  localparam int STEP_W      = 2 * DIM_W;
  localparam int MAX_DIM_DEF = 4096;

  // pixel samples
  localparam int SAMPLE_W = 8;
  localparam int IN_W     = 3 * SAMPLE_W;
  localparam int OUT_W    = 4 * SAMPLE_W;

  // configuration port
  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 4'd0,
    CFG_SRC_HEIGHT = 4'd1,
    CFG_OUT_WIDTH  = 4'd2,
    CFG_OUT_HEIGHT = 4'd3
  } cfg_idx_t;

  // register values after reset
  localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 13'd1080;
  localparam logic [DIM_W-1:0] RST_OUT_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_OUT_HEIGHT = 13'd360;
  // steps for the reset sizes: 1920/640 and 1080/360, both 3 remainder 0
  localparam logic [STEP_W-1:0] RST_COL_STEP = {13'd3, 13'd0};
  localparam logic [STEP_W-1:0] RST_ROW_STEP = {13'd3, 13'd0};

  // color arithmetic, 20-bit signed intermediate
  localparam int ACC_W = 20;
  localparam logic signed [ACC_W-1:0] COEF_CB_B = 20'sd475;
  localparam logic signed [ACC_W-1:0] COEF_CB_G = 20'sd48;
  localparam logic signed [ACC_W-1:0] COEF_CR_G = 20'sd120;
  localparam logic signed [ACC_W-1:0] COEF_CR_R = 20'sd403;
  localparam logic signed [ACC_W-1:0] ROUND_C   = 20'sd128;
  localparam logic [SAMPLE_W-1:0]     CHROMA_MID = 8'd128;
  localparam logic [SAMPLE_W-1:0]     ALPHA_OPAQUE = 8'd255;

  // control states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_DIV  = 3'b100
  } ctrl_state_t;

endpackage

`default_nettype wire

[hw/rtl/ycbcr_to_bgra_nearest_scaler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ycbcr_to_bgra_nearest_scaler: nearest-neighbor downscaler with color convert
// Picks source pixels of a raster stream for the output grid and turns each
// picked one into a BGRA pixel with BT.709 full-range integer terms.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock while no step recompute runs and
// the output does not hold it back, and passes a picked pixel out through the
// input register, then color math into the output register. Source pixels
// that are not picked produce no result. Reset and every register write
// restart the frame and recompute the column and row steps in a restoring
// divider that retires one quotient bit per cycle; in_tready stays low after
// reset is released and after each write, through the load state and then
// the divide steps. Writes to an index beyond the four registers are ignored.
module ycbcr_to_bgra_nearest_scaler
  import ycbs_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // source pixels
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [IN_W-1:0]      in_tdata,   // luma, cb, cr
  // output pixels
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // blue, green, red, alpha
  output logic                 out_tlast,  // row_end
  output logic                 out_tuser,  // frame_end
  // register writes
  input  wire                  cfg_wr_en,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [DIM_W-1:0]     cfg_wdata
);

  localparam logic [DIM_W+1:0] MAX_DIM_C = (DIM_W+2)'(MAX_DIM);
  localparam logic [3:0]       DIV_LAST  = 4'(DIM_W - 1);

  // one restoring divide step: returns {remainder, quotient}
  function automatic logic [STEP_W-1:0] div_step(input logic [DIM_W-1:0] rem,
                                                 input logic [DIM_W-1:0] quo,
                                                 input logic [DIM_W-1:0] dvs);
    logic [DIM_W:0] sh;
    logic [DIM_W:0] diff;
    logic           fit;
    sh   = {rem, quo[DIM_W-1]};
    diff = sh - {1'b0, dvs};
    fit  = (sh >= {1'b0, dvs});
    return {fit ? diff[DIM_W-1:0] : sh[DIM_W-1:0], quo[DIM_W-2:0], fit};
  endfunction

  // clamp and floor-shift a color sum to a byte
  function automatic logic [SAMPLE_W-1:0] to_byte(input logic signed [ACC_W-1:0] v);
    logic [SAMPLE_W-1:0] res;
    if (v[ACC_W-1]) begin
      res = '0;
    end else if (v[ACC_W-2:16] != '0) begin
      res = '1;
    end else begin
      res = v[15:8];
    end
    return res;
  endfunction

  // configuration registers
  logic [DIM_W-1:0] cfg_sw_r, cfg_sh_r, cfg_ow_r, cfg_oh_r;
  logic             cfg_hit;

  always_comb begin
    case (cfg_index)
      CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_OUT_WIDTH, CFG_OUT_HEIGHT: cfg_hit = cfg_wr_en;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sw_r <= RST_SRC_WIDTH;
      cfg_sh_r <= RST_SRC_HEIGHT;
      cfg_ow_r <= RST_OUT_WIDTH;
      cfg_oh_r <= RST_OUT_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  cfg_sw_r <= cfg_wdata;
        CFG_SRC_HEIGHT: cfg_sh_r <= cfg_wdata;
        CFG_OUT_WIDTH:  cfg_ow_r <= cfg_wdata;
        CFG_OUT_HEIGHT: cfg_oh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective sizes: zero taken as one, source limited to MAX_DIM, output to source
  logic [DIM_W-1:0] lim_w, lim_h, lim_ow, lim_oh;

  always_comb begin
    if ({2'b0, cfg_sw_r} > MAX_DIM_C) lim_w = DIM_W'(MAX_DIM);
    else if (cfg_sw_r == '0)          lim_w = DIM_W'(1);
    else                              lim_w = cfg_sw_r;
    if ({2'b0, cfg_sh_r} > MAX_DIM_C) lim_h = DIM_W'(MAX_DIM);
    else if (cfg_sh_r == '0)          lim_h = DIM_W'(1);
    else                              lim_h = cfg_sh_r;
    if (cfg_ow_r == '0)               lim_ow = DIM_W'(1);
    else if (cfg_ow_r > lim_w)        lim_ow = lim_w;
    else                              lim_ow = cfg_ow_r;
    if (cfg_oh_r == '0)               lim_oh = DIM_W'(1);
    else if (cfg_oh_r > lim_h)        lim_oh = lim_h;
    else                              lim_oh = cfg_oh_r;
  end

  // step computation sequencer and dividers
  ctrl_state_t       state_r;
  logic [3:0]        div_cnt_r;
  logic [DIM_W-1:0]  eff_w_r, eff_h_r, eff_ow_r, eff_oh_r;
  logic [DIM_W-1:0]  cq_r, crem_r, rq_r, rrem_r;
  logic [STEP_W-1:0] col_step_r, row_step_r;
  logic [STEP_W-1:0] cdiv_nxt, rdiv_nxt;

  assign cdiv_nxt = div_step(crem_r, cq_r, eff_ow_r);
  assign rdiv_nxt = div_step(rrem_r, rq_r, eff_oh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      div_cnt_r  <= '0;
      eff_w_r    <= RST_SRC_WIDTH;
      eff_h_r    <= RST_SRC_HEIGHT;
      eff_ow_r   <= RST_OUT_WIDTH;
      eff_oh_r   <= RST_OUT_HEIGHT;
      col_step_r <= RST_COL_STEP;
      row_step_r <= RST_ROW_STEP;
    end else if (cfg_hit) begin
      state_r <= ST_LOAD;
    end else begin
      case (state_r)
        ST_LOAD: begin
          eff_w_r   <= lim_w;
          eff_h_r   <= lim_h;
          eff_ow_r  <= lim_ow;
          eff_oh_r  <= lim_oh;
          div_cnt_r <= '0;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + 4'd1;
          if (div_cnt_r == DIV_LAST) begin
            col_step_r <= {cdiv_nxt[DIM_W-1:0], cdiv_nxt[STEP_W-1:DIM_W]};
            row_step_r <= {rdiv_nxt[DIM_W-1:0], rdiv_nxt[STEP_W-1:DIM_W]};
            state_r    <= ST_IDLE;
          end
        end
        ST_IDLE: ;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // divider datapath: dividend shifts through the quotient register
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      cq_r   <= lim_w;
      crem_r <= '0;
      rq_r   <= lim_h;
      rrem_r <= '0;
    end else begin
      cq_r   <= cdiv_nxt[DIM_W-1:0];
      crem_r <= cdiv_nxt[STEP_W-1:DIM_W];
      rq_r   <= rdiv_nxt[DIM_W-1:0];
      rrem_r <= rdiv_nxt[STEP_W-1:DIM_W];
    end
  end

  // handshake
  logic s1_valid_r, s1_adv, in_acc;

  assign s1_adv    = !out_tvalid || out_tready;
  assign in_tready = (state_r == ST_IDLE) && (!s1_valid_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  // position state
  logic [DIM_W-1:0] src_col_r, src_row_r, out_col_r, out_row_r;
  logic [DIM_W-1:0] pick_col_r, col_rest_r, pick_row_r, row_rest_r;

  logic             row_sel, pick, last_col, last_row, row_done, frame_done;
  logic [DIM_W:0]   col_sum, row_sum, src_col_inc, src_row_inc;
  logic             col_wrap, row_wrap;
  logic [DIM_W:0]   pick_col_sum, pick_row_sum, col_rest_sub, row_rest_sub;

  always_comb begin
    row_sel  = (out_row_r < eff_oh_r) && (src_row_r == pick_row_r);
    pick     = row_sel && (out_col_r < eff_ow_r) && (src_col_r == pick_col_r);
    last_col = (out_col_r == eff_ow_r - DIM_W'(1));
    last_row = (out_row_r == eff_oh_r - DIM_W'(1));

    // next picked column: add quotient, carry the remainder
    col_sum      = {1'b0, col_rest_r} + {1'b0, col_step_r[DIM_W-1:0]};
    col_wrap     = (col_sum >= {1'b0, eff_ow_r});
    col_rest_sub = col_sum - {1'b0, eff_ow_r};
    pick_col_sum = {1'b0, pick_col_r} + {1'b0, col_step_r[STEP_W-1:DIM_W]}
                   + {{DIM_W{1'b0}}, col_wrap};

    // next picked row
    row_sum      = {1'b0, row_rest_r} + {1'b0, row_step_r[DIM_W-1:0]};
    row_wrap     = (row_sum >= {1'b0, eff_oh_r});
    row_rest_sub = row_sum - {1'b0, eff_oh_r};
    pick_row_sum = {1'b0, pick_row_r} + {1'b0, row_step_r[STEP_W-1:DIM_W]}
                   + {{DIM_W{1'b0}}, row_wrap};

    src_col_inc = {1'b0, src_col_r} + (DIM_W+1)'(1);
    src_row_inc = {1'b0, src_row_r} + (DIM_W+1)'(1);
    row_done    = (src_col_inc >= {1'b0, eff_w_r});
    frame_done  = (src_row_inc >= {1'b0, eff_h_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      src_col_r  <= '0;
      src_row_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      pick_col_r <= '0;
      col_rest_r <= '0;
      pick_row_r <= '0;
      row_rest_r <= '0;
    end else if (in_acc) begin
      if (row_done) begin
        src_col_r  <= '0;
        out_col_r  <= '0;
        pick_col_r <= '0;
        col_rest_r <= '0;
        if (frame_done) begin
          src_row_r  <= '0;
          out_row_r  <= '0;
          pick_row_r <= '0;
          row_rest_r <= '0;
        end else begin
          src_row_r <= src_row_inc[DIM_W-1:0];
          if (row_sel) begin
            out_row_r  <= out_row_r + DIM_W'(1);
            pick_row_r <= pick_row_sum[DIM_W-1:0];
            row_rest_r <= row_wrap ? row_rest_sub[DIM_W-1:0] : row_sum[DIM_W-1:0];
          end
        end
      end else begin
        src_col_r <= src_col_inc[DIM_W-1:0];
        if (pick) begin
          out_col_r  <= out_col_r + DIM_W'(1);
          pick_col_r <= pick_col_sum[DIM_W-1:0];
          col_rest_r <= col_wrap ? col_rest_sub[DIM_W-1:0] : col_sum[DIM_W-1:0];
        end
      end
    end
  end

  // input register: picked samples and end marks
  logic [SAMPLE_W-1:0] s1_luma_r, s1_cb_r, s1_cr_r;
  logic                s1_row_end_r, s1_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= pick;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_luma_r      <= in_tdata[SAMPLE_W-1:0];
      s1_cb_r        <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
      s1_cr_r        <= in_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
      s1_row_end_r   <= last_col;
      s1_frame_end_r <= last_col && last_row;
    end
  end

  // color conversion
  logic signed [ACC_W-1:0]    luma_s, d_s, e_s, b_sum, g_sum, r_sum;
  logic signed [SAMPLE_W:0]   d9, e9;

  always_comb begin
    d9     = $signed({1'b0, s1_cb_r} - {1'b0, CHROMA_MID});
    e9     = $signed({1'b0, s1_cr_r} - {1'b0, CHROMA_MID});
    d_s    = ACC_W'(d9);
    e_s    = ACC_W'(e9);
    luma_s = $signed({{(ACC_W-SAMPLE_W-8){1'b0}}, s1_luma_r, 8'd0});
    b_sum  = luma_s + COEF_CB_B * d_s + ROUND_C;
    g_sum  = luma_s - COEF_CB_G * d_s - COEF_CR_G * e_s + ROUND_C;
    r_sum  = luma_s + COEF_CR_R * e_s + ROUND_C;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (s1_adv) begin
      out_tvalid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_tdata <= {ALPHA_OPAQUE, to_byte(r_sum), to_byte(g_sum), to_byte(b_sum)};
      out_tlast <= s1_row_end_r;
      out_tuser <= s1_frame_end_r;
    end
  end

  // checks
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser || out_tlast))
    else $error("frame end without row end");

  a_busy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> !in_tready)
    else $error("request accepted while steps are recomputed");

  a_out_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_col_r <= eff_ow_r)
    else $error("output column beyond output width");

  a_col_rest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (col_rest_r < eff_ow_r && row_rest_r < eff_oh_r))
    else $error("pick remainder not below divisor");

endmodule

`default_nettype wire

[verif/tb_ycbcr_to_bgra_nearest_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ycbcr_to_bgra_nearest_scaler: self-checking bench for the BGRA scaler
// Streams source pixels under many frame and output sizes, predicts which
// pixels get picked and their BGRA color, and checks every output pixel,
// including row and frame end flags, against that prediction in order.
// ----------------------------------------------------------------------------
module tb_ycbcr_to_bgra_nearest_scaler;
  import ycbs_pkg::*;

  localparam int NUM_CFG_REGS   = int'(CFG_OUT_HEIGHT) + 1;
  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RANDOM_PIXELS  = 1250;
  localparam int MAX_PHASE_PIX  = 300;
  localparam logic [DIM_W-1:0] DIM_ALL_ONES = '1;

  // expected output pixel
  typedef struct {
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] alpha;
    logic                row_end;
    logic                frame_end;
  } bgra_pixel_t;

  typedef enum logic [1:0] {
    READY_FREE,
    READY_SPARSE,
    READY_TOGGLE,
    READY_RANDOM
  } ready_mode_t;

  // picks source pixels for the output grid and converts them to bgra
  class pixel_scoreboard;
    logic [DIM_W-1:0]  reg_src_w, reg_src_h, reg_out_w, reg_out_h;
    logic [DIM_W-1:0]  lim_w, lim_h, lim_ow, lim_oh;
    logic [DIM_W-1:0]  src_col, src_row, out_col, out_row;
    logic [DIM_W-1:0]  pick_col, pick_col_rem, pick_row, pick_row_rem;
    logic [STEP_W-1:0] col_step, row_step;
    bgra_pixel_t       pending[$];
    int errors, checked, row_ends, frame_ends;

    function new();
      reg_src_w  = RST_SRC_WIDTH;
      reg_src_h  = RST_SRC_HEIGHT;
      reg_out_w  = RST_OUT_WIDTH;
      reg_out_h  = RST_OUT_HEIGHT;
      errors     = 0;
      checked    = 0;
      row_ends   = 0;
      frame_ends = 0;
      retune();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("check failed: %s", msg);
    endtask

    function logic [DIM_W-1:0] limit_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
      if (v == '0) return DIM_W'(1);
      if (v > hi) return hi;
      return v;
    endfunction

    function void restart();
      src_col      = '0;
      src_row      = '0;
      out_col      = '0;
      out_row      = '0;
      pick_col     = '0;
      pick_col_rem = '0;
      pick_row     = '0;
      pick_row_rem = '0;
    endfunction

    // effective sizes and quotient/remainder steps
    function void retune();
      lim_w    = limit_dim(reg_src_w, DIM_W'(MAX_DIM_DEF));
      lim_h    = limit_dim(reg_src_h, DIM_W'(MAX_DIM_DEF));
      lim_ow   = limit_dim(reg_out_w, lim_w);
      lim_oh   = limit_dim(reg_out_h, lim_h);
      col_step = {lim_w / lim_ow, lim_w % lim_ow};
      row_step = {lim_h / lim_oh, lim_h % lim_oh};
      restart();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      case (idx)
        CFG_SRC_WIDTH:  reg_src_w = value;
        CFG_SRC_HEIGHT: reg_src_h = value;
        CFG_OUT_WIDTH:  reg_out_w = value;
        CFG_OUT_HEIGHT: reg_out_h = value;
        default: return;
      endcase
      retune();
    endfunction

    // next picked position: add quotient, carry the remainder
    function logic [2*DIM_W-1:0] next_pick(logic [DIM_W-1:0] pick, logic [DIM_W-1:0] rem,
                                           logic [STEP_W-1:0] step, logic [DIM_W-1:0] div);
      logic [DIM_W:0]   rem_sum;
      logic [DIM_W-1:0] pick_sum;
      rem_sum  = {1'b0, rem} + {1'b0, step[DIM_W-1:0]};
      pick_sum = pick + step[STEP_W-1:DIM_W];
      if (rem_sum >= {1'b0, div}) begin
        rem_sum  = rem_sum - {1'b0, div};
        pick_sum = pick_sum + 1'b1;
      end
      return {pick_sum, rem_sum[DIM_W-1:0]};
    endfunction

    // floor shift by 8, then clamp to a byte
    function logic [SAMPLE_W-1:0] to_sample(int acc);
      int s;
      s = acc >>> 8;
      if (s < 0) return '0;
      if (s > 255) return '1;
      return s[SAMPLE_W-1:0];
    endfunction

    function void note_request(logic [SAMPLE_W-1:0] luma, logic [SAMPLE_W-1:0] cb,
                               logic [SAMPLE_W-1:0] cr);
      bgra_pixel_t px;
      bit          row_hit;
      int          c, d, e;
      row_hit = (out_row < lim_oh) && (src_row == pick_row);
      // picked source pixel becomes one output pixel
      if (row_hit && out_col < lim_ow && src_col == pick_col) begin
        c = int'(luma);
        d = int'(cb) - 128;
        e = int'(cr) - 128;
        px.blue      = to_sample(256 * c + 475 * d + 128);
        px.green     = to_sample(256 * c - 48 * d - 120 * e + 128);
        px.red       = to_sample(256 * c + 403 * e + 128);
        px.alpha     = ALPHA_OPAQUE;
        px.row_end   = (out_col == lim_ow - 1'b1);
        px.frame_end = px.row_end && (out_row == lim_oh - 1'b1);
        pending.insert(pending.size(), px);
        out_col = out_col + 1'b1;
        {pick_col, pick_col_rem} = next_pick(pick_col, pick_col_rem, col_step, lim_ow);
      end
      // raster position, row advance and frame wrap
      if ({1'b0, src_col} + 1'b1 >= {1'b0, lim_w}) begin
        src_col      = '0;
        out_col      = '0;
        pick_col     = '0;
        pick_col_rem = '0;
        if (row_hit) begin
          out_row = out_row + 1'b1;
          {pick_row, pick_row_rem} = next_pick(pick_row, pick_row_rem, row_step, lim_oh);
        end
        src_row = src_row + 1'b1;
        if (src_row >= lim_h) restart();
      end else begin
        src_col = src_col + 1'b1;
      end
    endfunction

    task compare_field(string name, logic [SAMPLE_W-1:0] got, logic [SAMPLE_W-1:0] want);
      if (got !== want)
        report($sformatf("pixel %0d %s got %0d want %0d", checked, name, got, want));
    endtask

    task check_result(logic [OUT_W-1:0] data, logic last, logic user);
      bgra_pixel_t want;
      checked++;
      if (last === 1'b1) row_ends++;
      if (user === 1'b1) frame_ends++;
      if (pending.size() == 0) begin
        report($sformatf("pixel %0d arrived with none expected", checked));
        return;
      end
      want = pending.pop_front();
      compare_field("blue", data[7:0], want.blue);
      compare_field("green", data[15:8], want.green);
      compare_field("red", data[23:16], want.red);
      compare_field("alpha", data[31:24], want.alpha);
      compare_field("row_end", {7'd0, last}, {7'd0, want.row_end});
      compare_field("frame_end", {7'd0, user}, {7'd0, want.frame_end});
    endtask

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;   // luma, cb, cr
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;       // blue, green, red, alpha
  logic                 out_tlast;       // row_end
  logic                 out_tuser;       // frame_end
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;

  pixel_scoreboard sb;
  int          pixels_sent = 0;
  int          random_pixels = 0;
  int          reg_writes = 0;
  int          size_settings = 0;
  int          burst_left = 1;
  int          idle_cycles = 0;
  ready_mode_t ready_mode = READY_FREE;
  int          ready_left = 0;

  // directed colors: all corners of the sample cube, gray and nominal levels
  logic [IN_W-1:0] edge_colors [12] = '{
    24'h000000, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF,
    24'h808080, 24'h808000, 24'h8080FF, 24'h8080EB
  };

  ycbcr_to_bgra_nearest_scaler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern: segments of free, sparse, toggling or random ready
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(4, 40);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      READY_FREE:   out_tready <= 1'b1;
      READY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      READY_TOGGLE: out_tready <= !out_tready;
      default:      out_tready <= $urandom_range(0, 1);
    endcase
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return SAMPLE_W'($urandom_range(0, 255));
  endfunction

  // one source pixel request, with bursts and gaps on the sender side
  task automatic push_pixel(logic [SAMPLE_W-1:0] luma, logic [SAMPLE_W-1:0] cb,
                            logic [SAMPLE_W-1:0] cr);
    in_tvalid <= 1'b1;
    in_tdata  <= {cr, cb, luma};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(luma, cb, cr);
    pixels_sent++;
    if (burst_left <= 1) begin
      in_tvalid  <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // stop sending and wait for every expected pixel
  task automatic drain_results(bit pause_after);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    if (pause_after) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, value);
    reg_writes++;
    @(posedge clk);
    // step recompute holds off the input side
    if (idx < NUM_CFG_REGS) begin
      while (!in_tready) @(posedge clk);
    end
  endtask

  task automatic write_unused_index();
    write_register(CFG_IDX_W'(NUM_CFG_REGS
                              + $urandom_range(0, (1 << CFG_IDX_W) - 1 - NUM_CFG_REGS)),
                   DIM_W'($urandom_range(0, 8191)));
  endtask

  // all four sizes, starting at a random register
  task automatic set_sizes(logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh,
                           logic [DIM_W-1:0] ow, logic [DIM_W-1:0] oh);
    logic [DIM_W-1:0] sizes [NUM_CFG_REGS];
    int               first;
    sizes[CFG_SRC_WIDTH]  = sw;
    sizes[CFG_SRC_HEIGHT] = sh;
    sizes[CFG_OUT_WIDTH]  = ow;
    sizes[CFG_OUT_HEIGHT] = oh;
    first = $urandom_range(0, NUM_CFG_REGS - 1);
    for (int k = 0; k < NUM_CFG_REGS; k++)
      write_register(CFG_IDX_W'((first + k) % NUM_CFG_REGS), sizes[(first + k) % NUM_CFG_REGS]);
    size_settings++;
  endtask

  task automatic push_random_run(int n, bit hold_midway);
    for (int i = 0; i < n; i++) begin
      if (hold_midway && i == n / 2) drain_results(1'b0);
      push_pixel(pick_sample(), pick_sample(), pick_sample());
      random_pixels++;
    end
  endtask

  initial begin
    logic [DIM_W-1:0] sw, sh, ow, oh;
    int               frame_px, n, kind;
    bit               first_random;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    // reset sizes, one third of the columns picked on every third row
    push_random_run(40, 1'b0);
    drain_results(1'b1);

    // directed: every pixel picked, frame wraps every four pixels
    write_unused_index();
    set_sizes(13'd2, 13'd2, 13'd2, 13'd2);
    foreach (edge_colors[i]) push_pixel(edge_colors[i][7:0], edge_colors[i][15:8],
                                        edge_colors[i][23:16]);
    drain_results(1'b1);
    // zero sizes taken as one: each pixel is a whole frame
    set_sizes(13'd0, 13'd0, 13'd0, 13'd0);
    for (int i = 0; i < 6; i++) push_pixel(pick_sample(), pick_sample(), pick_sample());
    drain_results(1'b1);
    // oversize values clamp to the largest frame with no scaling
    set_sizes(DIM_ALL_ONES, DIM_ALL_ONES, DIM_ALL_ONES, DIM_ALL_ONES);
    for (int i = 0; i < 6; i++) push_pixel(pick_sample(), pick_sample(), pick_sample());
    drain_results(1'b1);

    // random phases over many frame and output sizes
    first_random = 1'b1;
    while (random_pixels < RANDOM_PIXELS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          sw = DIM_W'($urandom_range(1024, 4096));
          sh = DIM_W'($urandom_range(2, 4096));
          ow = DIM_W'($urandom_range(1, sw));
          oh = DIM_W'($urandom_range(1, sh));
        end
        1, 2: begin
          sw = DIM_W'($urandom_range(0, 12));
          sh = DIM_W'($urandom_range(0, 12));
          ow = DIM_W'($urandom_range(0, 16));
          oh = DIM_W'($urandom_range(0, 16));
        end
        3: begin
          sw = DIM_W'($urandom_range(0, 8191));
          sh = DIM_W'($urandom_range(0, 8191));
          ow = DIM_W'($urandom_range(0, 8191));
          oh = DIM_W'($urandom_range(0, 8191));
        end
        default: begin
          sw = DIM_W'($urandom_range(2, 24));
          sh = DIM_W'($urandom_range(2, 10));
          ow = DIM_W'($urandom_range(1, sw));
          oh = DIM_W'($urandom_range(1, sh));
        end
      endcase
      set_sizes(sw, sh, ow, oh);
      if ($urandom_range(0, 3) == 0) write_unused_index();
      frame_px = int'(sb.lim_w) * int'(sb.lim_h);
      n = frame_px * $urandom_range(1, 2) + $urandom_range(0, int'(sb.lim_w));
      if (n > MAX_PHASE_PIX) n = 120 + $urandom_range(0, 60);
      push_random_run(n, first_random || $urandom_range(0, 2) == 0);
      first_random = 1'b0;
      drain_results(1'b1);
    end

    // let any stray output show up
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d source pixels under %0d size settings and %0d register writes",
             pixels_sent, size_settings + 1, reg_writes);
    $display("checked %0d output pixels, %0d row ends, %0d frame ends",
             sb.checked, sb.row_ends, sb.frame_ends);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
